FILE: rtl/kcl_pkg.sv
package kcl_pkg;

  localparam int NV = 32;
  localparam int VW = 5;
  localparam int DW = 6;

  // Depth of the queue between front and back, a power of two.
  localparam int QD  = 4;
  localparam int QAW = $clog2(QD);

  typedef logic [NV-1:0] vmask_t;
  typedef logic [VW-1:0] vidx_t;

  // Register indexes of the configuration port.
  localparam logic CFG_K = 1'b0;
  localparam logic CFG_N = 1'b1;

  // One classified input beat, handed from the front to the back.
  typedef struct packed {
    logic  do_edge;
    logic  last;
    vidx_t a;
    vidx_t b;
  } cmd_t;

  // Mask of the low n bits, n saturated to NV.
  function automatic vmask_t low_mask(input logic [5:0] n);
    vmask_t m;
    m = '0;
    for (int i = 0; i < NV; i++) begin
      if (i < int'(n)) m[i] = 1'b1;
    end
    return m;
  endfunction

endpackage

FILE: rtl/kcl_front.sv
module kcl_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  kcl_pkg::vidx_t   in_vertex_a,
  input  kcl_pkg::vidx_t   in_vertex_b,
  input  logic             in_edge_valid,
  input  logic             in_last_edge,
  output logic             q_valid,
  input  logic             q_pop,
  output kcl_pkg::cmd_t    q_cmd
);
  import kcl_pkg::*;

  cmd_t             mem_r [QD];
  logic [QAW-1:0]   wp_r, rp_r, wp_nxt, rp_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             push;
  cmd_t             c;

  // Classify the incoming beat; beats with no edge and no marker are dropped.
  always_comb begin
    c.do_edge = in_edge_valid;
    c.last    = in_last_edge;
    c.a       = in_vertex_a;
    c.b       = in_vertex_b;
  end

  assign in_stall = (cnt_r == (QAW+1)'(QD));
  assign push     = in_valid && !in_stall && (in_edge_valid || in_last_edge);
  assign q_valid  = (cnt_r != '0);
  assign q_cmd    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r + QAW'(push);
    rp_nxt  = rp_r + QAW'(q_pop);
    cnt_nxt = cnt_r + (QAW+1)'(push) - (QAW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= c;
  end

endmodule

FILE: rtl/kcl_back.sv
module kcl_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [6:0]       k_thr,
  input  logic [5:0]       n_act,
  input  logic             q_valid,
  output logic             q_pop,
  input  kcl_pkg::cmd_t    q_cmd,
  output logic             out_valid,
  input  logic             out_stall,
  output kcl_pkg::vidx_t   out_vertex_index,
  output kcl_pkg::vidx_t   out_component_number,
  output logic             out_last_of_component,
  output logic             out_last_of_run,
  output logic             out_no_survivors,
  output logic             busy
);
  import kcl_pkg::*;

  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_CLEAR = 8'b0000_0010,
    S_PEEL  = 8'b0000_0100,
    S_SEED  = 8'b0000_1000,
    S_GROW  = 8'b0001_0000,
    S_EMIT  = 8'b0010_0000,
    S_EMPTY = 8'b0100_0000,
    S_WIPE  = 8'b1000_0000
  } st_t;

  st_t             st_r, st_nxt;
  vmask_t          adj_r [NV];
  vmask_t          alive_r, seen_r, comp_r, pend_r;
  vidx_t           cno_r;
  logic            any_r;
  logic            ov_r;
  vidx_t           ov_idx_r, ov_cno_r;
  logic            ov_loc_r, ov_lor_r, ov_ns_r;
  vmask_t          vmask;
  logic            free;
  vmask_t          row_or;
  vmask_t          low;
  vidx_t           first_s;
  logic            found_s;
  vidx_t           first_v;
  logic            found_v;
  logic [5:0]      live_deg [NV];

  assign vmask = low_mask(n_act);
  assign free  = !ov_r || !out_stall;
  assign busy  = (st_r != S_LOAD) || ov_r;
  assign q_pop = (st_r == S_LOAD) && q_valid && !q_cmd.last ||
                 (st_r == S_LOAD) && q_valid && q_cmd.last;

  // Live degree of each vertex within the current alive set.
  always_comb begin
    for (int v = 0; v < NV; v++) live_deg[v] = 6'($countones(adj_r[v] & alive_r));
  end

  // Union of adjacency rows of the current component.
  always_comb begin
    row_or = comp_r;
    for (int v = 0; v < NV; v++) if (comp_r[v]) row_or = row_or | adj_r[v];
  end

  // Lowest alive, unseen seed and lowest member still to emit.
  always_comb begin
    first_s = '0; found_s = 1'b0;
    first_v = '0; found_v = 1'b0;
    for (int i = NV-1; i >= 0; i--) begin
      if (alive_r[i] && !seen_r[i]) begin first_s = VW'(i); found_s = 1'b1; end
      if (pend_r[i]) begin first_v = VW'(i); found_v = 1'b1; end
    end
    low = pend_r & ~(vmask_t'(1) << first_v);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_LOAD:  if (q_valid && q_cmd.last) st_nxt = S_CLEAR;
      S_CLEAR: st_nxt = S_PEEL;
      S_PEEL: begin
        st_nxt = S_SEED;
        for (int v = 0; v < NV; v++)
          if (alive_r[v] && (7'(live_deg[v]) < k_thr)) st_nxt = S_PEEL;
      end
      S_SEED:  st_nxt = found_s ? S_GROW : (any_r ? S_WIPE : S_EMPTY);
      S_GROW:  if ((row_or & alive_r) == comp_r) st_nxt = S_EMIT;
      S_EMIT:  if (free && (low == '0)) st_nxt = S_SEED;
      S_EMPTY: if (free) st_nxt = S_WIPE;
      S_WIPE:  if (!ov_r) st_nxt = S_LOAD;
      default: st_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (free) ov_r <= (st_r == S_EMIT) || (st_r == S_EMPTY);
    end
  end

  // Peeling removes every low-degree vertex at once per pass; the fixed point is
  // the same as the cascade.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < NV; v++) adj_r[v] <= '0;
      alive_r <= '1; seen_r <= '0; comp_r <= '0; pend_r <= '0;
      cno_r <= '0; any_r <= 1'b0;
    end else begin
      case (st_r)
        S_LOAD: if (q_valid && q_cmd.do_edge) begin
          if (q_cmd.a != q_cmd.b && vmask[q_cmd.a] && vmask[q_cmd.b] &&
              !adj_r[q_cmd.a][q_cmd.b]) begin
            adj_r[q_cmd.a][q_cmd.b] <= 1'b1;
            adj_r[q_cmd.b][q_cmd.a] <= 1'b1;
          end
        end
        S_CLEAR: begin
          alive_r <= vmask;
          seen_r  <= '0;
          cno_r   <= '0;
          any_r   <= 1'b0;
          for (int v = 0; v < NV; v++) adj_r[v] <= adj_r[v] & vmask;
        end
        S_PEEL: begin
          for (int v = 0; v < NV; v++)
            if (alive_r[v] && (7'(live_deg[v]) < k_thr)) alive_r[v] <= 1'b0;
        end
        S_SEED: if (found_s) comp_r <= vmask_t'(1) << first_s;
        S_GROW: begin
          comp_r <= row_or & alive_r;
          if ((row_or & alive_r) == comp_r) begin
            pend_r <= comp_r;
            seen_r <= seen_r | comp_r;
          end
        end
        S_EMIT: if (free) begin
          pend_r <= low;
          any_r  <= 1'b1;
          if (low == '0) cno_r <= cno_r + VW'(1);
        end
        S_WIPE: begin
          for (int v = 0; v < NV; v++) adj_r[v] <= '0;
          alive_r <= '1; seen_r <= '0; comp_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // Output register; last_of_run is found by looking for any unseen survivor.
  always_ff @(posedge clk) begin
    if (st_r == S_EMIT && free) begin
      ov_idx_r <= first_v;
      ov_cno_r <= cno_r;
      ov_loc_r <= (low == '0);
      ov_lor_r <= (low == '0) && ((alive_r & ~seen_r) == '0);
      ov_ns_r  <= 1'b0;
    end else if (st_r == S_EMPTY && free) begin
      ov_idx_r <= '0; ov_cno_r <= '0; ov_loc_r <= 1'b0;
      ov_lor_r <= 1'b0; ov_ns_r <= 1'b1;
    end
  end

  assign out_valid             = ov_r;
  assign out_vertex_index      = ov_idx_r;
  assign out_component_number  = ov_cno_r;
  assign out_last_of_component = ov_loc_r;
  assign out_last_of_run       = ov_lor_r;
  assign out_no_survivors      = ov_ns_r;

endmodule

FILE: rtl/kcore_component_labeler_unit.sv
// Edge beats are taken one per cycle into a four-entry queue while it has
// room, and loaded into the adjacency matrix at one per cycle while the back
// end is loading. The beat with last_edge set starts a run: a clear step,
// peeling passes (at most 33), then for every component a seed step, growth
// steps and one result beat per member, then one more seed step that finds no
// survivor left, one empty-core beat when nothing survives, and a final wipe
// that waits for the output stage to drain. Input is held off once the queue
// fills during a run; results leave through a registered output stage.
module kcore_component_labeler_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  kcl_pkg::vidx_t      in_vertex_a,
  input  kcl_pkg::vidx_t      in_vertex_b,
  input  logic                in_edge_valid,
  input  logic                in_last_edge,
  output logic                out_valid,
  input  logic                out_stall,
  output kcl_pkg::vidx_t      out_vertex_index,
  output kcl_pkg::vidx_t      out_component_number,
  output logic                out_last_of_component,
  output logic                out_last_of_run,
  output logic                out_no_survivors,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [6:0]          cfg_data
);
  import kcl_pkg::*;

  logic [6:0] k_r;
  logic [5:0] n_r;
  logic [5:0] n_act;
  logic       q_valid, q_pop, busy;
  cmd_t       q_cmd;

  assign cfg_ready = 1'b1;
  assign n_act     = (n_r > 6'(NV)) ? 6'(NV) : n_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
      n_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_K:   k_r <= cfg_data;
        CFG_N:   n_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  kcl_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_vertex_a, .in_vertex_b,
    .in_edge_valid, .in_last_edge, .q_valid, .q_pop, .q_cmd
  );

  kcl_back u_back (
    .clk, .rst_n, .k_thr(k_r), .n_act, .q_valid, .q_pop, .q_cmd,
    .out_valid, .out_stall, .out_vertex_index, .out_component_number,
    .out_last_of_component, .out_last_of_run, .out_no_survivors, .busy
  );

  // An empty-core beat carries no other flag.
  a_ns_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_survivors |-> !out_last_of_run && !out_last_of_component)
    else $error("empty-core beat carries flags");

  // The end of a run always closes a component.
  a_run_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |-> out_last_of_component)
    else $error("run ended inside a component");

  // A result beat only appears while the back end is busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result while idle");

endmodule

FILE: dv/kcl_core_checker.sv
module kcl_core_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  kcl_pkg::vidx_t in_vertex_a,
  input  kcl_pkg::vidx_t in_vertex_b,
  input  logic           in_edge_valid,
  input  logic           in_last_edge,
  input  logic           out_valid,
  input  logic           out_stall,
  input  kcl_pkg::vidx_t out_vertex_index,
  input  kcl_pkg::vidx_t out_component_number,
  input  logic           out_last_of_component,
  input  logic           out_last_of_run,
  input  logic           out_no_survivors,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [6:0]     cfg_data,
  output int             fail_count,
  output int             labels_pending
);
  import kcl_pkg::*;

  typedef struct packed {
    vidx_t vtx;
    vidx_t comp;
    logic  comp_end;
    logic  run_end;
    logic  empty_core;
  } label_t;

  label_t     expected_labels[$];
  logic [6:0] k_reg;
  logic [5:0] count_reg;
  vmask_t     adj_rows[NV];

  // Prints one line per mismatch and counts it.
  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Loads the edge of one beat; on the last beat, peels the graph down to its
  // k-core and labels every survivor, or appends one empty-core label if none.
  task automatic label_core(input vidx_t a, input vidx_t b, input logic has_edge,
                            input logic is_last);
    int     n, head, tail, cno, kk;
    int     dg[NV];
    int     wq[NV];
    vmask_t vm, alive, seen, comp, grow, row_or;
    label_t run_q[$];
    label_t r;
    n = (count_reg > 6'd32) ? 32 : int'(count_reg);
    kk = int'(k_reg);
    if (has_edge && a != b && int'(a) < n && int'(b) < n && !adj_rows[a][b]) begin
      adj_rows[a][b] = 1'b1;
      adj_rows[b][a] = 1'b1;
    end
    if (!is_last) return;
    vm = low_mask(6'(n));
    alive = vm;
    head = 0;
    tail = 0;
    for (int v = 0; v < n; v++) begin
      dg[v] = $countones(adj_rows[v] & vm);
      if (dg[v] < kk && tail < NV) begin
        wq[tail] = v;
        tail++;
      end
    end
    // Cascade: a neighbor joins the queue when its degree first drops below k.
    while (head < tail) begin
      int v;
      v = wq[head];
      head++;
      if (alive[v]) begin
        alive[v] = 1'b0;
        for (int u = 0; u < n; u++) begin
          if (adj_rows[v][u] && alive[u]) begin
            dg[u]--;
            if (kk > 0 && dg[u] + 1 == kk && tail < NV) begin
              wq[tail] = u;
              tail++;
            end
          end
        end
      end
    end
    // Grow each component from its least unseen survivor.
    seen = '0;
    cno = 0;
    for (int s = 0; s < n; s++) begin
      if (alive[s] && !seen[s]) begin
        comp = vmask_t'(1) << s;
        forever begin
          row_or = comp;
          for (int v = 0; v < n; v++) if (comp[v]) row_or |= adj_rows[v];
          grow = row_or & alive;
          if (grow == comp) break;
          comp = grow;
        end
        seen |= comp;
        for (int v = 0; v < n; v++) begin
          if (comp[v]) begin
            r.vtx = vidx_t'(v);
            r.comp = vidx_t'(cno);
            r.comp_end = ((comp >> v) <= 1);
            r.run_end = 1'b0;
            r.empty_core = 1'b0;
            run_q.push_back(r);
          end
        end
        cno++;
      end
    end
    if (run_q.size() == 0) begin
      r = '0;
      r.empty_core = 1'b1;
      run_q.push_back(r);
    end else begin
      run_q[run_q.size()-1].run_end = 1'b1;
    end
    foreach (run_q[i]) expected_labels.push_back(run_q[i]);
    for (int v = 0; v < NV; v++) adj_rows[v] = '0;
  endtask

  // Sample every channel at the clock edge; results are checked before the
  // beat of the same edge is predicted.
  always @(posedge clk) begin
    if (!rst_n) begin
      k_reg = '0;
      count_reg = '0;
      for (int v = 0; v < NV; v++) adj_rows[v] = '0;
      expected_labels.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_labels.size() == 0) begin
          report($sformatf("unexpected result vertex %0d", out_vertex_index));
        end else begin
          label_t e;
          e = expected_labels.pop_front();
          if (out_vertex_index !== e.vtx)
            report($sformatf("vertex_index %0d, want %0d", out_vertex_index, e.vtx));
          if (out_component_number !== e.comp)
            report($sformatf("component_number %0d, want %0d",
                             out_component_number, e.comp));
          if (out_last_of_component !== e.comp_end)
            report($sformatf("last_of_component %b, want %b",
                             out_last_of_component, e.comp_end));
          if (out_last_of_run !== e.run_end)
            report($sformatf("last_of_run %b, want %b", out_last_of_run, e.run_end));
          if (out_no_survivors !== e.empty_core)
            report($sformatf("no_survivors %b, want %b", out_no_survivors, e.empty_core));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_K) k_reg = cfg_data;
        else count_reg = cfg_data[5:0];
      end
      if (in_valid && !in_stall)
        label_core(in_vertex_a, in_vertex_b, in_edge_valid, in_last_edge);
    end
    labels_pending = expected_labels.size();
  end

  initial begin
    fail_count = 0;
    labels_pending = 0;
  end

endmodule

FILE: dv/kcore_component_labeler_unit_tb.sv
module kcore_component_labeler_unit_tb;
  import kcl_pkg::*;

  localparam int WATCHDOG_LIMIT = 8000;
  localparam int DRAIN_CYCLES = 80;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  vidx_t      in_vertex_a;
  vidx_t      in_vertex_b;
  logic       in_edge_valid;
  logic       in_last_edge;
  logic       out_valid;
  logic       out_stall;
  vidx_t      out_vertex_index;
  vidx_t      out_component_number;
  logic       out_last_of_component;
  logic       out_last_of_run;
  logic       out_no_survivors;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [6:0] cfg_data;
  int         fail_count;
  int         labels_pending;
  logic       quiet;
  int         stall_left;
  int         idle_cycles;
  int         beats_sent;
  int         cur_n;

  kcore_component_labeler_unit u_dut (.*);

  kcl_core_checker u_checker (.*);

  // Clock with a 12 unit period.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side stalls in random bursts until the quiet tail of the run.
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Ends the run when no channel has moved a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Sends one edge beat; called at a rising edge and returns at the edge that
  // accepts the beat.
  task automatic send_edge(input int a, input int b, input logic ev, input logic lst);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vertex_a <= vidx_t'(a);
    in_vertex_b <= vidx_t'(b);
    in_edge_valid <= ev;
    in_last_edge <= lst;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    beats_sent++;
  endtask

  // Waits until every label has come out and the block has wound down.
  task automatic drain_labels();
    in_valid <= 1'b0;
    @(posedge clk);
    while (labels_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes one register while the block is idle.
  task automatic write_reg(input logic idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 7'(value);
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_graph(input int k, input int n);
    drain_labels();
    write_reg(CFG_K, k);
    write_reg(CFG_N, n);
    cur_n = (n > 32) ? 32 : n;
  endtask

  // One random graph: mostly in-range edges, a little noise, last flag at end.
  task automatic send_graph(input int edges);
    int a, b, span;
    span = (cur_n < 2) ? 2 : cur_n;
    for (int i = 0; i < edges; i++) begin
      a = $urandom_range(0, span - 1);
      b = $urandom_range(0, span - 1);
      case ($urandom_range(0, 15))
        0: b = a;
        1: a = $urandom_range(0, 31);
        2: b = $urandom_range(0, 31);
        default: ;
      endcase
      send_edge(a, b, ($urandom_range(0, 9) != 0), 1'b0);
    end
    send_edge($urandom_range(0, span - 1), $urandom_range(0, span - 1),
              $urandom_range(0, 1), 1'b1);
  endtask

  initial begin
    int k_pick, n_pick;
    rst_n = 1'b0;
    quiet = 1'b0;
    in_valid = 1'b0;
    in_vertex_a = '0;
    in_vertex_b = '0;
    in_edge_valid = 1'b0;
    in_last_edge = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_K;
    cfg_data = '0;
    beats_sent = 0;
    cur_n = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at reset: no vertices, so the core is empty.
    send_edge(0, 1, 1'b1, 1'b1);

    // Full size with k of zero: extreme indices, a self-loop, a repeated pair,
    // a beat with no edge and no marker, then an edge loaded with the last flag.
    set_graph(0, 32);
    send_edge(0, 31, 1'b1, 1'b0);
    send_edge(31, 0, 1'b1, 1'b0);
    send_edge(5, 5, 1'b1, 1'b0);
    send_edge(7, 8, 1'b0, 1'b0);
    send_edge(30, 29, 1'b1, 1'b1);

    // Triangle plus a pendant vertex under k of two.
    set_graph(2, 5);
    send_edge(0, 1, 1'b1, 1'b0);
    send_edge(1, 2, 1'b1, 1'b0);
    send_edge(2, 0, 1'b1, 1'b0);
    send_edge(2, 3, 1'b1, 1'b0);
    send_edge(4, 6, 1'b1, 1'b1);

    // A threshold of 64 peels everything; oversized count saturates.
    set_graph(64, 63);
    send_edge(1, 2, 1'b1, 1'b1);
    set_graph(1, 40);
    send_edge(31, 30, 1'b1, 1'b0);
    send_edge(3, 4, 1'b1, 1'b1);

    // Count lowered while a graph is loading drops the outer vertices.
    set_graph(1, 10);
    send_edge(1, 9, 1'b1, 1'b0);
    send_edge(2, 3, 1'b1, 1'b0);
    set_graph(1, 5);
    send_edge(3, 4, 1'b1, 1'b1);

    // Random phases with random and extreme settings.
    while (beats_sent < 330) begin
      case ($urandom_range(0, 5))
        0: k_pick = 0;
        1: k_pick = 64;
        default: k_pick = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 5))
        0: n_pick = 32;
        1: n_pick = $urandom_range(0, 2);
        2: n_pick = $urandom_range(33, 63);
        default: n_pick = $urandom_range(3, 16);
      endcase
      set_graph(k_pick, n_pick);
      for (int g = 0; g < 3; g++) begin
        if (beats_sent > 290) quiet = 1'b1;
        send_graph($urandom_range(1, 30));
      end
    end

    drain_labels();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: kcore_component_labeler_unit.f
rtl/kcl_pkg.sv
rtl/kcl_front.sv
rtl/kcl_back.sv
rtl/kcore_component_labeler_unit.sv
dv/kcl_core_checker.sv
dv/kcore_component_labeler_unit_tb.sv
